>>> design/soc_pkg.sv
// shared constants, codes and control types for the sorted array occurrence counter
package soc_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int VALUE_W     = 32;
	localparam int ADDR_W      = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W       = CNT_W + 1;
	localparam int OCC_W       = 11;
	localparam int SUM_W       = (IDX_W > OCC_W) ? IDX_W : OCC_W;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = ((OCC_W + 7) / 8) * 8;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE_L,
		ST_CMP_L,
		ST_PROBE_R,
		ST_CMP_R,
		ST_EMIT
	} soc_state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic compare;
		logic toward_left;
		logic switch_right;
		logic emit;
	} soc_cmd_t;

	typedef struct packed {
		logic range_empty;
		logic found_none;
		logic out_free;
	} soc_status_t;

endpackage

>>> design/sorted_array_occurrence_count_top.sv
// top level of the sorted array occurrence counter
// a load transaction leaves the block ready again in the next cycle
// a query runs a search for the lower bound and then the upper bound over the n stored elements;
// each probe is a registered store read, then a bound update; the input is ready again
// in the same cycle as the result turns valid, and no new query is taken while one is in progress
// arst_n clears the element count, the search state and the output valid; the store is not cleared
module sorted_array_occurrence_count_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [soc_pkg::VALUE_W-1:0]         s_tdata,  // value
	input  logic [soc_pkg::IN_TUSER_W-1:0]      s_tuser,  // kind, begin_array
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [soc_pkg::OUT_TDATA_W-1:0]     m_tdata   // occurrences, zero padding
);
	import soc_pkg::*;

	soc_cmd_t         cmd;
	soc_status_t      status;
	logic [OCC_W-1:0] occ;

	soc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser[0]),
		.status   (status),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	soc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_value  ($signed(s_tdata)),
		.in_begin  (s_tuser[1]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_occ   (occ),
		.status    (status)
	);

	assign m_tdata = OUT_TDATA_W'(occ);

endmodule

>>> design/soc_ctrl.sv
// controller state machine sequencing loads and the two bound searches
module soc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	input  soc_pkg::soc_status_t status,
	output logic                in_ready,
	output soc_pkg::soc_cmd_t   cmd
);
	import soc_pkg::*;

	soc_state_t state_q;
	soc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (in_kind == KIND_QUERY)) begin
					state_d = ST_PROBE_L;
				end
			end
			ST_PROBE_L: begin
				if (!status.range_empty) begin
					state_d = ST_CMP_L;
				end else if (status.found_none) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_PROBE_R;
				end
			end
			ST_CMP_L: begin
				state_d = ST_PROBE_L;
			end
			ST_PROBE_R: begin
				if (status.range_empty) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CMP_R;
				end
			end
			ST_CMP_R: begin
				state_d = ST_PROBE_R;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid && (in_kind == KIND_LOAD);
				cmd.start = in_valid && (in_kind == KIND_QUERY);
			end
			ST_PROBE_L: begin
				cmd.issue        = !status.range_empty;
				cmd.switch_right = status.range_empty && !status.found_none;
			end
			ST_CMP_L: begin
				cmd.compare     = 1'b1;
				cmd.toward_left = 1'b1;
			end
			ST_PROBE_R: begin
				cmd.issue = !status.range_empty;
			end
			ST_CMP_R: begin
				cmd.compare = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> design/soc_datapath.sv
// element store, search bounds, probe compare and output register
module soc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  soc_pkg::soc_cmd_t                 cmd,
	input  logic signed [soc_pkg::VALUE_W-1:0] in_value,
	input  logic                              in_begin,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [soc_pkg::OCC_W-1:0]         out_occ,
	output soc_pkg::soc_status_t              status
);
	import soc_pkg::*;

	logic signed [VALUE_W-1:0] mem [STORE_DEPTH];
	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [IDX_W-1:0]   lo_q;
	logic signed [IDX_W-1:0]   hi_q;
	logic signed [IDX_W-1:0]   found_q;
	logic signed [IDX_W-1:0]   first_q;
	logic signed [IDX_W-1:0]   mid_q;
	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	logic [OCC_W-1:0]          occ_q;

	logic [CNT_W-1:0]          wr_idx;
	logic                      wr_en;
	logic signed [IDX_W-1:0]   span;
	logic signed [IDX_W-1:0]   mid;
	logic signed [IDX_W-1:0]   top_idx;
	logic signed [IDX_W-1:0]   mid_inc;
	logic signed [IDX_W-1:0]   mid_dec;
	logic signed [IDX_W-1:0]   bound_gap;
	logic [SUM_W-1:0]          total;
	logic [OCC_W-1:0]          occ_d;

	assign wr_idx    = in_begin ? '0 : count_q;
	assign wr_en     = cmd.load && (wr_idx < CNT_W'(STORE_DEPTH));
	assign span      = hi_q - lo_q;
	assign mid       = lo_q + (span >>> 1);
	assign top_idx   = $signed({1'b0, count_q}) - IDX_W'(1);
	assign mid_inc   = mid_q + IDX_W'(1);
	assign mid_dec   = mid_q - IDX_W'(1);
	assign bound_gap = found_q - first_q;
	assign total     = SUM_W'($unsigned(bound_gap)) + SUM_W'(1);

	always_comb begin
		if (found_q[IDX_W-1] || bound_gap[IDX_W-1]) begin
			occ_d = '0;
		end else begin
			occ_d = total[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[ADDR_W-1:0]] <= in_value;
		end
		if (cmd.issue) begin
			rd_q  <= mem[mid[ADDR_W-1:0]];
			mid_q <= mid;
		end
		if (cmd.start) begin
			key_q <= in_value;
		end
		if (cmd.switch_right) begin
			first_q <= found_q;
		end
		if (cmd.emit) begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			found_q     <= '0;
		end else begin
			if (cmd.load) begin
				if (wr_en) begin
					count_q <= wr_idx + CNT_W'(1);
				end else begin
					count_q <= wr_idx;
				end
			end
			if (cmd.start || cmd.switch_right) begin
				lo_q    <= '0;
				hi_q    <= top_idx;
				found_q <= '1;
			end else if (cmd.compare) begin
				if (rd_q == key_q) begin
					found_q <= mid_q;
					if (cmd.toward_left) begin
						hi_q <= mid_dec;
					end else begin
						lo_q <= mid_inc;
					end
				end else if (rd_q < key_q) begin
					lo_q <= mid_inc;
				end else begin
					hi_q <= mid_dec;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.range_empty = (lo_q > hi_q);
	assign status.found_none  = found_q[IDX_W-1];
	assign status.out_free    = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign out_occ            = occ_q;

endmodule

>>> design/soc_checker.sv
// port level checks for the occurrence counter and their bind to the top level
module soc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [soc_pkg::IN_TUSER_W-1:0]  s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [soc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import soc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a query transaction starts a search and blocks the input
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY) |=> !s_tready)
		else $error("input ready during search");

	// after a load transaction the input is ready again in the next cycle
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD) |=> s_tready)
		else $error("input not ready after load");

	// a new result only appears at the end of a search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without search");

	// padding above the count is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OCC_W] == '0))
		else $error("result padding not zero");

endmodule

bind sorted_array_occurrence_count_top soc_checker u_soc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
